/* rtl/sfcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] REQ_TERM  = 8'hFF;
    localparam logic [7:0] KIND_E    = 8'h45;
    localparam logic [7:0] KIND_S    = 8'h53;
    localparam logic [7:0] KIND_P    = 8'h50;
    localparam logic [7:0] KIND_H    = 8'h48;
    localparam logic [7:0] KIND_T    = 8'h54;
    localparam logic [7:0] KIND_V    = 8'h56;
    localparam logic [7:0] TAIL_BYTE = 8'h00;

    localparam int unsigned REPLY_LEN = 6;

    typedef enum logic [2:0] {
        POS_IDLE   = 3'd0,
        POS_SYNC   = 3'd1,
        POS_KIND   = 3'd2,
        POS_FIRST  = 3'd3,
        POS_SECOND = 3'd4,
        POS_TERM   = 3'd5
    } frame_pos_t;

    typedef enum logic [2:0] {
        IDX_SYNC0 = 3'd0,
        IDX_SYNC1 = 3'd1,
        IDX_KIND  = 3'd2,
        IDX_HIGH  = 3'd3,
        IDX_LOW   = 3'd4,
        IDX_TAIL  = 3'd5
    } reply_idx_t;

    typedef struct packed {
        logic        has_reply;
        logic [7:0]  kind;
        logic [15:0] value;
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [7:0]  shutter;
        logic [7:0]  plant;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/sfcd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sfcd_in_if;

    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [15:0] light_level;
    logic [15:0] soil_moisture;

    modport source (output valid, output rx_byte, output light_level, output soil_moisture,
                    input ready);
    modport sink (input valid, input rx_byte, input light_level, input soil_moisture,
                  output ready);

endinterface

`default_nettype wire

/* rtl/sfcd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sfcd_out_if;

    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last_of_run;
    logic [15:0] stored_temperature;
    logic [15:0] stored_humidity;
    logic [7:0]  stored_shutter;
    logic [7:0]  stored_plant;

    modport source (output valid, output tx_valid, output tx_byte, output last_of_run,
                    output stored_temperature, output stored_humidity,
                    output stored_shutter, output stored_plant,
                    input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input last_of_run,
                  input stored_temperature, input stored_humidity,
                  input stored_shutter, input stored_plant,
                  output ready);

endinterface

`default_nettype wire

/* rtl/sfcd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcd_front
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    sfcd_in_if.sink           in_ch,
    input  wire logic         queue_full,
    output logic              push,
    output sfcd_pkg::cmd_t    cmd
);

    import sfcd_pkg::*;

    logic        sync_half_seen_reg, sync_half_seen_next;
    frame_pos_t  frame_position_reg, frame_position_next;
    logic [7:0]  frame_kind_reg, frame_kind_next;
    logic [7:0]  first_payload_reg, first_payload_next;
    logic [7:0]  second_payload_reg, second_payload_next;
    logic [15:0] temperature_reg, temperature_next;
    logic [15:0] humidity_reg, humidity_next;
    logic [7:0]  shutter_reg, shutter_next;
    logic [7:0]  plant_reg, plant_next;

    logic        is_sync;
    frame_pos_t  pos_in;
    logic        frame_done;
    logic        has_reply;
    logic [15:0] reply_value;

    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    always_comb
    begin
        is_sync             = (in_ch.rx_byte == SYNC_BYTE);
        sync_half_seen_next = is_sync && !sync_half_seen_reg;
        pos_in              = (is_sync && sync_half_seen_reg) ? POS_SYNC : frame_position_reg;

        frame_position_next = frame_position_reg;
        frame_kind_next     = frame_kind_reg;
        first_payload_next  = first_payload_reg;
        second_payload_next = second_payload_reg;
        temperature_next    = temperature_reg;
        humidity_next       = humidity_reg;
        shutter_next        = shutter_reg;
        plant_next          = plant_reg;
        frame_done          = 1'b0;
        has_reply           = 1'b0;
        reply_value         = 16'h0000;

        unique case (pos_in)
            POS_TERM:
            begin
                frame_done          = 1'b1;
                frame_position_next = POS_IDLE;
            end
            POS_SECOND:
            begin
                second_payload_next = in_ch.rx_byte;
                frame_position_next = POS_TERM;
            end
            POS_FIRST:
            begin
                first_payload_next  = in_ch.rx_byte;
                frame_position_next = POS_SECOND;
            end
            POS_KIND:
            begin
                frame_kind_next     = in_ch.rx_byte;
                frame_position_next = POS_FIRST;
            end
            POS_SYNC:
            begin
                frame_position_next = POS_KIND;
            end
            default:
            begin
                frame_position_next = POS_IDLE;
            end
        endcase

        if (frame_done && in_ch.rx_byte == REQ_TERM)
        begin
            unique case (frame_kind_reg)
                KIND_E:
                begin
                    has_reply   = 1'b1;
                    reply_value = in_ch.light_level;
                end
                KIND_S:
                begin
                    has_reply   = 1'b1;
                    reply_value = in_ch.soil_moisture;
                end
                KIND_P:
                begin
                    has_reply   = 1'b1;
                    reply_value = {8'h00, plant_reg};
                end
                default:
                begin
                    has_reply   = 1'b0;
                end
            endcase
        end
        else if (frame_done)
        begin
            unique case (frame_kind_reg)
                KIND_H:  humidity_next    = {first_payload_reg, second_payload_reg};
                KIND_T:  temperature_next = {first_payload_reg, second_payload_reg};
                KIND_V:  shutter_next     = second_payload_reg;
                KIND_P:  plant_next       = second_payload_reg;
                default: plant_next       = plant_reg;
            endcase
        end

        cmd.has_reply   = has_reply;
        cmd.kind        = frame_kind_reg;
        cmd.value       = reply_value;
        cmd.temperature = temperature_next;
        cmd.humidity    = humidity_next;
        cmd.shutter     = shutter_next;
        cmd.plant       = plant_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_half_seen_reg <= 1'b0;
            frame_position_reg <= POS_IDLE;
            frame_kind_reg     <= 8'h00;
            first_payload_reg  <= 8'h00;
            second_payload_reg <= 8'h00;
            temperature_reg    <= 16'h0000;
            humidity_reg       <= 16'h0000;
            shutter_reg        <= 8'h00;
            plant_reg          <= 8'h00;
        end
        else if (push)
        begin
            sync_half_seen_reg <= sync_half_seen_next;
            frame_position_reg <= frame_position_next;
            frame_kind_reg     <= frame_kind_next;
            first_payload_reg  <= first_payload_next;
            second_payload_reg <= second_payload_next;
            temperature_reg    <= temperature_next;
            humidity_reg       <= humidity_next;
            shutter_reg        <= shutter_next;
            plant_reg          <= plant_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sfcd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcd_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sfcd_pkg::cmd_t push_data,
    input  wire logic           pop,
    output sfcd_pkg::cmd_t      head,
    output logic                full,
    output logic                not_empty
);

    import sfcd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/sfcd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcd_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sfcd_pkg::cmd_t head,
    input  wire logic           head_valid,
    output logic                pop,
    sfcd_out_if.source          out_ch
);

    import sfcd_pkg::*;

    reply_idx_t  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic [15:0] temperature_reg, humidity_reg;
    logic [7:0]  shutter_reg, plant_reg;

    logic        load;
    logic        emit;

    assign load = !out_valid_reg || out_ch.ready;
    assign emit = load && head_valid;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (load)
            out_valid_next = head_valid;

        if (emit)
        begin
            tx_valid_next = head.has_reply;
            if (head.has_reply)
            begin
                unique case (idx_reg)
                    IDX_SYNC0: tx_byte_next = SYNC_BYTE;
                    IDX_SYNC1: tx_byte_next = SYNC_BYTE;
                    IDX_KIND:  tx_byte_next = head.kind;
                    IDX_HIGH:  tx_byte_next = head.value[15:8];
                    IDX_LOW:   tx_byte_next = head.value[7:0];
                    IDX_TAIL:  tx_byte_next = TAIL_BYTE;
                    default:   tx_byte_next = TAIL_BYTE;
                endcase
            end
            else
            begin
                tx_byte_next = 8'h00;
            end

            last_next = !head.has_reply || (idx_reg == reply_idx_t'(REPLY_LEN - 1));
            if (last_next)
            begin
                pop      = 1'b1;
                idx_next = IDX_SYNC0;
            end
            else
            begin
                idx_next = reply_idx_t'(idx_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_SYNC0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg <= tx_valid_next;
        tx_byte_reg  <= tx_byte_next;
        last_reg     <= last_next;
        if (emit)
        begin
            temperature_reg <= head.temperature;
            humidity_reg    <= head.humidity;
            shutter_reg     <= head.shutter;
            plant_reg       <= head.plant;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.tx_valid           = tx_valid_reg;
    assign out_ch.tx_byte            = tx_byte_reg;
    assign out_ch.last_of_run        = last_reg;
    assign out_ch.stored_temperature = temperature_reg;
    assign out_ch.stored_humidity    = humidity_reg;
    assign out_ch.stored_shutter     = shutter_reg;
    assign out_ch.stored_plant       = plant_reg;

endmodule

`default_nettype wire

/* rtl/sync_frame_command_decoder.sv */
// Sync frame command decoder.
//
// in_ch carries received bytes together with the current light and soil
// moisture samples. Frames are 0x55 0x55, type, byte1, byte2, terminator;
// a terminator of 0xFF is a request, anything else an info frame that
// updates the stored temperature, humidity, shutter and plant values.
// out_ch carries one status transaction per byte (tx_valid 0), or six reply
// transactions (tx_valid 1) for an E, S or P request; last_of_run marks the
// final transaction of each byte. Every transaction also shows the stored
// values as they stand after that byte.
// Throughput: one byte per cycle for status-only bytes while out_ch.ready
// is high; a request with a reply occupies the output side for six
// transactions, one reply byte per cycle while out_ch.ready is high.
// The decode front and the output sequencer are joined by a queue of
// QUEUE_DEPTH commands; in_ch.ready drops only when that queue is full.
// Reset clears the frame state, the stored values and the queue.
// When the receiver stalls, the output register holds its transaction and
// the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_command_decoder
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfcd_in_if.sink    in_ch,
    sfcd_out_if.source out_ch
);

    import sfcd_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_not_empty;

    sfcd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (front_cmd)
    );

    sfcd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    sfcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (queue_not_empty),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

/* rtl/sfcd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module sfcd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        tx_valid,
    input wire logic [7:0]  tx_byte,
    input wire logic        last_of_run,
    input wire logic [15:0] stored_temperature,
    input wire logic [15:0] stored_humidity,
    input wire logic [7:0]  stored_shutter,
    input wire logic [7:0]  stored_plant
);

    // stalled transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_valid) && $stable(tx_byte)
            && $stable(last_of_run))
        else $error("stalled output transaction changed");

    // status results carry no byte and close their run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'h00 && last_of_run)
        else $error("status transaction malformed");

    // reply bytes follow one another with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && tx_valid && !last_of_run |=> out_valid && tx_valid)
        else $error("reply run broken");

    // stored values do not move inside a reply run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && tx_valid && !last_of_run |=>
            $stable(stored_temperature) && $stable(stored_humidity)
            && $stable(stored_shutter) && $stable(stored_plant))
        else $error("stored values changed within reply");

endmodule

bind sync_frame_command_decoder sfcd_checker u_sfcd_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .tx_valid           (out_ch.tx_valid),
    .tx_byte            (out_ch.tx_byte),
    .last_of_run        (out_ch.last_of_run),
    .stored_temperature (out_ch.stored_temperature),
    .stored_humidity    (out_ch.stored_humidity),
    .stored_shutter     (out_ch.stored_shutter),
    .stored_plant       (out_ch.stored_plant)
);

`default_nettype wire

/* tb/sv/frame_result_checker.sv */
`timescale 1ns / 1ps

module frame_result_checker
    import sfcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfcd_in_if          in_ch,
    sfcd_out_if         out_ch,
    output int unsigned errors,
    output int unsigned outstanding
);

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [7:0]  shutter;
        logic [7:0]  plant;
    } tx_result_t;

    tx_result_t expected_tx[$];
    tx_result_t want;

    logic        sync_half;
    frame_pos_t  position;
    logic [7:0]  kind;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [7:0]  shutter;
    logic [7:0]  plant;

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s got %h expected %h", name, got, exp_val));
    endtask

    task automatic push_result(input logic v, input logic [7:0] b, input logic last);
        expected_tx.push_back('{v, b, last, temperature, humidity, shutter, plant});
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic [15:0] light,
                               input logic [15:0] soil);
        logic        frame_done;
        logic        request;
        logic        reply;
        logic [15:0] value;

        frame_done = 1'b0;
        request    = 1'b0;
        reply      = 1'b0;
        value      = '0;

        if (b == SYNC_BYTE && !sync_half)
            sync_half = 1'b1;
        else if (b == SYNC_BYTE)
        begin
            position  = POS_SYNC;
            sync_half = 1'b0;
        end
        else
            sync_half = 1'b0;

        case (position)
            POS_TERM:
            begin
                request    = (b == REQ_TERM);
                frame_done = 1'b1;
            end
            POS_SECOND:
            begin
                second_byte = b;
                position    = POS_TERM;
            end
            POS_FIRST:
            begin
                first_byte = b;
                position   = POS_SECOND;
            end
            POS_KIND:
            begin
                kind     = b;
                position = POS_FIRST;
            end
            POS_SYNC: position = POS_KIND;
            default:  position = POS_IDLE;
        endcase

        if (frame_done)
        begin
            position = POS_IDLE;
            if (request)
            begin
                case (kind)
                    KIND_E:
                    begin
                        value = light;
                        reply = 1'b1;
                    end
                    KIND_S:
                    begin
                        value = soil;
                        reply = 1'b1;
                    end
                    KIND_P:
                    begin
                        value = {8'h00, plant};
                        reply = 1'b1;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (kind)
                    KIND_H:  humidity    = {first_byte, second_byte};
                    KIND_T:  temperature = {first_byte, second_byte};
                    KIND_V:  shutter     = second_byte;
                    KIND_P:  plant       = second_byte;
                    default: ;
                endcase
            end
        end

        if (reply)
        begin
            push_result(1'b1, SYNC_BYTE, 1'b0);
            push_result(1'b1, SYNC_BYTE, 1'b0);
            push_result(1'b1, kind, 1'b0);
            push_result(1'b1, value[15:8], 1'b0);
            push_result(1'b1, value[7:0], 1'b0);
            push_result(1'b1, TAIL_BYTE, 1'b1);
        end
        else
            push_result(1'b0, 8'h00, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_half   = 1'b0;
            position    = POS_IDLE;
            kind        = '0;
            first_byte  = '0;
            second_byte = '0;
            temperature = '0;
            humidity    = '0;
            shutter     = '0;
            plant       = '0;
            errors      = 0;
            expected_tx.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.rx_byte, in_ch.light_level, in_ch.soil_moisture);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_tx.size() == 0)
                    report("output transaction with nothing expected");
                else
                begin
                    want = expected_tx.pop_front();
                    check_field("tx_valid", out_ch.tx_valid, want.tx_valid);
                    check_field("tx_byte", out_ch.tx_byte, want.tx_byte);
                    check_field("last_of_run", out_ch.last_of_run, want.last_of_run);
                    check_field("stored_temperature", out_ch.stored_temperature,
                                want.temperature);
                    check_field("stored_humidity", out_ch.stored_humidity, want.humidity);
                    check_field("stored_shutter", out_ch.stored_shutter, want.shutter);
                    check_field("stored_plant", out_ch.stored_plant, want.plant);
                end
            end
            outstanding <= expected_tx.size();
        end
    end

endmodule

/* tb/sv/sync_frame_command_decoder_test.sv */
`timescale 1ns / 1ps

module sync_frame_command_decoder_test;

    import sfcd_pkg::*;

    localparam int unsigned CLK_PERIOD     = 12;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    bit          calm;
    int unsigned holds_asked;
    int unsigned holds_done;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    int unsigned fail_count;
    int unsigned results_pending;

    sfcd_in_if  in_ch ();
    sfcd_out_if out_ch ();

    sync_frame_command_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    frame_result_checker u_results (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .errors      (fail_count),
        .outstanding (results_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [15:0] light,
                             input logic [15:0] soil);
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= b;
        in_ch.light_level   <= light;
        in_ch.soil_moisture <= soil;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] kind, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] term,
                              input logic [15:0] light, input logic [15:0] soil);
        send_byte(SYNC_BYTE, rand_word(), rand_word());
        send_byte(SYNC_BYTE, rand_word(), rand_word());
        send_byte(kind, rand_word(), rand_word());
        send_byte(b1, rand_word(), rand_word());
        send_byte(b2, rand_word(), rand_word());
        send_byte(term, light, soil);
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        logic [7:0]  kind;

        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 6))
                0:       kind = KIND_E;
                1:       kind = KIND_S;
                2:       kind = KIND_P;
                3:       kind = KIND_H;
                4:       kind = KIND_T;
                5:       kind = KIND_V;
                default: kind = rand_byte();
            endcase
            if ($urandom_range(0, 99) < 75)
                send_frame(kind, rand_byte(), rand_byte(),
                           $urandom_range(0, 1) ? REQ_TERM : rand_byte(),
                           rand_word(), rand_word());
            else if ($urandom_range(0, 1))
                send_byte(rand_byte(), rand_word(), rand_word());
            else
            begin
                // frame cut short after the type
                send_byte(SYNC_BYTE, rand_word(), rand_word());
                send_byte(SYNC_BYTE, rand_word(), rand_word());
                send_byte(kind, rand_word(), rand_word());
            end
        end
    endtask

    // receiver side
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.rx_byte       <= '0;
        in_ch.light_level   <= '0;
        in_ch.soil_moisture <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_byte(8'hFF, 16'h0000, 16'hFFFF);
        send_frame(KIND_P, 8'h00, 8'hA5, 8'h7E, rand_word(), rand_word());
        send_frame(KIND_P, 8'hFF, 8'h00, REQ_TERM, 16'h0000, 16'h0000);
        // sync pair inside the payload restarts the frame
        send_byte(SYNC_BYTE, rand_word(), rand_word());
        send_byte(SYNC_BYTE, rand_word(), rand_word());
        send_byte(KIND_E, rand_word(), rand_word());
        send_frame(KIND_S, 8'h12, 8'h34, REQ_TERM, 16'h0000, 16'hFFFF);
        send_frame(KIND_E, 8'h00, 8'h00, REQ_TERM, 16'hFFFF, 16'h0000);

        random_traffic(15);

        calm = 1'b1;
        random_traffic(15);

        // receiver holds off while requests keep coming
        holds_asked++;
        repeat (4)
            send_frame($urandom_range(0, 1) ? KIND_E : KIND_S, rand_byte(), rand_byte(),
                       REQ_TERM, rand_word(), rand_word());
        calm = 1'b0;

        random_traffic(20);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sfcd_pkg.sv
rtl/sfcd_in_if.sv
rtl/sfcd_out_if.sv
rtl/sfcd_front.sv
rtl/sfcd_queue.sv
rtl/sfcd_back.sv
rtl/sync_frame_command_decoder.sv
rtl/sfcd_checker.sv
tb/sv/frame_result_checker.sv
tb/sv/sync_frame_command_decoder_test.sv
